FILE: rtl/binary_search_table_macros.svh
// Assertion macros shared by the binary search table RTL.
// BST_ASSERT_SAME checks a consequent in the same cycle as its antecedent.
// BST_ASSERT_NEXT checks a consequent in the cycle after its antecedent.
// Both reduce to nothing when SYNTH is defined.
`ifndef BINARY_SEARCH_TABLE_MACROS_SVH
`define BINARY_SEARCH_TABLE_MACROS_SVH

`ifndef SYNTH

`define BST_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("binary search table: same-cycle check failed");

`define BST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("binary search table: next-cycle check failed");

`else

`define BST_ASSERT_SAME(label, clk, rst, ante, cons)

`define BST_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/bst_pkg.sv
package bst_pkg;

   // Fixed widths of the word fields.
   localparam int INDEX_W = 10;
   localparam int VALUE_W = 32;

   // Operation codes carried by req_op.
   typedef enum logic {
      OP_WRITE  = 1'b0,
      OP_SEARCH = 1'b1
   } op_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_COMPARE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic write;       // store the incoming word into the table
      logic load;        // capture the search window and key
      logic probe;       // read the midpoint entry
      logic update;      // narrow the window after a mismatch
      logic reply_hit;   // report the match at the probed index
      logic reply_miss;  // report not found
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic window_empty;  // low has passed high
      logic match;         // probed entry equals the key
   } status_type;

endpackage

FILE: rtl/bst_ram.sv
module bst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/bst_ctrl.sv
module bst_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                req_op,
   input  bst_pkg::status_type status,
   output logic                busy,
   output bst_pkg::cmd_type    cmd
);

   bst_pkg::state_type state_ff;
   bst_pkg::state_type state_in;
   logic               accept;

   // A word is taken only while no search is running.
   assign accept = start && (state_ff == bst_pkg::ST_IDLE);
   assign busy   = (state_ff != bst_pkg::ST_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bst_pkg::ST_IDLE: begin
            if (accept && (req_op == bst_pkg::OP_SEARCH)) begin
               state_in = bst_pkg::ST_CHECK;
            end
         end
         bst_pkg::ST_CHECK: begin
            if (status.window_empty) begin
               state_in = bst_pkg::ST_IDLE;
            end else begin
               state_in = bst_pkg::ST_COMPARE;
            end
         end
         bst_pkg::ST_COMPARE: begin
            if (status.match) begin
               state_in = bst_pkg::ST_IDLE;
            end else begin
               state_in = bst_pkg::ST_CHECK;
            end
         end
         default: begin
            state_in = bst_pkg::ST_IDLE;
         end
      endcase
   end

   // Commands for the datapath.
   always_comb begin
      cmd = '0;
      case (state_ff)
         bst_pkg::ST_IDLE: begin
            cmd.write = accept && (req_op == bst_pkg::OP_WRITE);
            cmd.load  = accept && (req_op == bst_pkg::OP_SEARCH);
         end
         bst_pkg::ST_CHECK: begin
            cmd.reply_miss = status.window_empty;
            cmd.probe      = !status.window_empty;
         end
         bst_pkg::ST_COMPARE: begin
            cmd.reply_hit = status.match;
            cmd.update    = !status.match;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bst_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/bst_datapath.sv
`include "binary_search_table_macros.svh"

module bst_datapath #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  bst_pkg::cmd_type                  cmd,
   output bst_pkg::status_type               status,
   input  logic [bst_pkg::INDEX_W-1:0]       req_write_index,
   input  logic signed [bst_pkg::VALUE_W-1:0] req_write_value,
   input  logic [bst_pkg::INDEX_W-1:0]       req_low_index,
   input  logic [bst_pkg::INDEX_W-1:0]       req_high_index,
   input  logic signed [bst_pkg::VALUE_W-1:0] req_search_key,
   output logic                              rsp_valid,
   output logic                              rsp_found,
   output logic [bst_pkg::INDEX_W-1:0]       rsp_position
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int IW = (AW > bst_pkg::INDEX_W) ? AW : bst_pkg::INDEX_W;
   // Bound width: a sign bit plus a spare bit so low can step past the last index.
   localparam int BW = IW + 2;
   localparam int PAD = BW - bst_pkg::INDEX_W;
   localparam logic signed [BW-1:0] LAST_INDEX = BW'(TABLE_DEPTH - 1);
   localparam logic [BW-1:0] DEPTH_C = BW'(TABLE_DEPTH);

   // Window bounds carry a sign bit: high may drop to minus one, and low may
   // step one past the last index.
   logic signed [BW-1:0]              lo_ff, lo_in;
   logic signed [BW-1:0]              hi_ff, hi_in;
   logic [IW-1:0]                     mid_ff;
   logic signed [bst_pkg::VALUE_W-1:0] key_ff;
   logic                              rsp_valid_ff;
   logic                              rsp_found_ff;
   logic [bst_pkg::INDEX_W-1:0]       rsp_position_ff;

   logic signed [BW-1:0]              high_ext;
   logic signed [BW-1:0]              high_sat;
   logic signed [BW-1:0]              mid_w;
   logic signed [BW-1:0]              mid_ext;
   logic [bst_pkg::INDEX_W-1:0]       mid_index;
   logic [BW-1:0]                     wr_index_ext;
   logic                              wr_en;
   logic [bst_pkg::VALUE_W-1:0]       rd_data;
   logic                              entry_less;

   // Window setup: the high bound saturates to the last entry.
   assign high_ext = $signed({{PAD{1'b0}}, req_high_index});
   assign high_sat = (high_ext > LAST_INDEX) ? LAST_INDEX : high_ext;

   // Midpoint of the current window.
   assign mid_w     = lo_ff + ((hi_ff - lo_ff) >>> 1);
   assign mid_ext   = $signed({2'b00, mid_ff});
   assign mid_index = mid_ff[bst_pkg::INDEX_W-1:0];

   // Writes beyond the table are dropped.
   assign wr_index_ext = {{PAD{1'b0}}, req_write_index};
   assign wr_en        = cmd.write && (wr_index_ext < DEPTH_C);

   bst_ram #(
      .WIDTH (bst_pkg::VALUE_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_index_ext[AW-1:0]),
      .wr_data (req_write_value),
      .rd_en   (cmd.probe),
      .rd_addr (mid_w[AW-1:0]),
      .rd_data (rd_data)
   );

   // Compare the probed entry against the key.
   assign status.match        = ($signed(rd_data) == key_ff);
   assign entry_less          = ($signed(rd_data) < key_ff);
   assign status.window_empty = (lo_ff > hi_ff);

   // Window narrowing.
   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.load) begin
         lo_in = $signed({{PAD{1'b0}}, req_low_index});
         hi_in = high_sat;
      end else if (cmd.update) begin
         if (entry_less) begin
            lo_in = mid_ext + BW'(1);
         end else begin
            hi_in = mid_ext - BW'(1);
         end
      end
   end

   // Search registers.
   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      if (cmd.load) begin
         key_ff <= req_search_key;
      end
      if (cmd.probe) begin
         mid_ff <= mid_w[IW-1:0];
      end
   end

   // Result word, shown for one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.reply_hit || cmd.reply_miss;
      end
      if (cmd.reply_hit) begin
         rsp_found_ff    <= 1'b1;
         rsp_position_ff <= mid_index;
      end else if (cmd.reply_miss) begin
         rsp_found_ff    <= 1'b0;
         rsp_position_ff <= '0;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

   // A probe always lands inside a non-empty window within the table.
   `BST_ASSERT_SAME(a_probe_nonempty, clock, reset, cmd.probe, lo_ff <= hi_ff)
   `BST_ASSERT_SAME(a_probe_in_table, clock, reset, cmd.probe, hi_ff <= LAST_INDEX)
   // A hit reports found with the probed index.
   `BST_ASSERT_NEXT(a_hit_found, clock, reset, cmd.reply_hit, rsp_valid && rsp_found)
   `BST_ASSERT_NEXT(a_hit_position, clock, reset, cmd.reply_hit, rsp_position == mid_index)
   // A miss reports not found at position zero.
   `BST_ASSERT_NEXT(a_miss_found, clock, reset, cmd.reply_miss, rsp_valid && !rsp_found)
   `BST_ASSERT_NEXT(a_miss_position, clock, reset, cmd.reply_miss, rsp_position == '0)

endmodule

FILE: rtl/binary_search_table.sv
// Channel   Ports                                   Handshake
// request   req_op req_write_index req_write_value  taken at a clock edge with
//           req_low_index req_high_index            start high and busy low
//           req_search_key
// response  rsp_found rsp_position                  rsp_valid high one cycle
//
// A write word is stored at the edge that takes it and leaves busy low.
// A search holds busy for each probe through a registered table read and then a
// compare, plus a final check when the window empties: at most eleven probes
// over 1024 entries; the result strobe follows in the next cycle.
// Reset is synchronous and clears the controller and the strobe, not the
// table. The receiver cannot stall: each result shows for exactly one cycle.
module binary_search_table #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_op,
   input  logic [bst_pkg::INDEX_W-1:0]        req_write_index,
   input  logic signed [bst_pkg::VALUE_W-1:0] req_write_value,
   input  logic [bst_pkg::INDEX_W-1:0]        req_low_index,
   input  logic [bst_pkg::INDEX_W-1:0]        req_high_index,
   input  logic signed [bst_pkg::VALUE_W-1:0] req_search_key,
   output logic                               rsp_valid,
   output logic                               rsp_found,
   output logic [bst_pkg::INDEX_W-1:0]        rsp_position
);

   bst_pkg::cmd_type    cmd;
   bst_pkg::status_type status;

   // Search sequencing.
   bst_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .req_op (req_op),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   // Table, window registers and result word.
   bst_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_write_index (req_write_index),
      .req_write_value (req_write_value),
      .req_low_index   (req_low_index),
      .req_high_index  (req_high_index),
      .req_search_key  (req_search_key),
      .rsp_valid       (rsp_valid),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position)
   );

endmodule
